### design/lsk_pkg.sv
package lsk_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_BYTES  = (WORD_W + POS_W + 7) / 8;
  localparam int TDATA_W     = DATA_BYTES * 8;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CHANGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic load;
  } cell_ctrl_t;

endpackage

### design/lsk_cell.sv
module lsk_cell (
  input  logic                            clk,
  input  lsk_pkg::cell_ctrl_t             ctrl,
  input  logic signed [lsk_pkg::WORD_W-1:0] above,
  input  logic signed [lsk_pkg::WORD_W-1:0] below,
  input  logic signed [lsk_pkg::WORD_W-1:0] value,
  output logic signed [lsk_pkg::WORD_W-1:0] word
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      word <= above;
    end else if (ctrl.pop) begin
      word <= below;
    end else if (ctrl.load) begin
      word <= value;
    end
  end

endmodule

### design/lifo_stack_with_peek_and_modify.sv
// bounded lifo of signed words held in a chain of cells, top of stack in cell 0
// result beat is registered and presented in the cycle after the request beat is taken
// throughput: one request per cycle while no result is stalled; push and pop shift the whole chain at once
// a result waiting on m_tready holds off new requests only while it is stalled
// reset (rst, synchronous): stack empty, no result pending; stored words undefined
module lifo_stack_with_peek_and_modify (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lsk_pkg::TDATA_W-1:0]   s_tdata,  // value[31:0], position[36:32], zero pad
  input  logic [1:0]                    s_tuser,  // opcode[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lsk_pkg::TDATA_W-1:0]   m_tdata,  // data[31:0], depth_now[36:32], zero pad
  output logic [1:0]                    m_tuser   // status[1:0]
);

  localparam int N = lsk_pkg::STACK_DEPTH;
  localparam int W = lsk_pkg::WORD_W;

  lsk_pkg::op_t                     op;
  logic signed [W-1:0]              value;
  logic [lsk_pkg::POS_W-1:0]        position;
  logic                             take;

  logic [lsk_pkg::CNT_W-1:0]        fill;
  logic [lsk_pkg::CNT_W-1:0]        fill_next;
  logic [lsk_pkg::CMP_W-1:0]        fill_ext;
  logic [lsk_pkg::CMP_W-1:0]        fill_next_ext;
  logic [lsk_pkg::CMP_W-1:0]        pos_ext;

  logic signed [W-1:0]              words [N];
  logic [N-1:0]                     hit;
  logic signed [W-1:0]              sel_word;

  logic                             is_empty;
  logic                             is_full;
  logic                             in_range;
  lsk_pkg::status_t                 status_next;
  logic signed [W-1:0]              data_next;

  logic                             out_valid;
  logic signed [W-1:0]              out_data;
  lsk_pkg::status_t                 out_status;
  logic [lsk_pkg::POS_W-1:0]        out_depth;

  assign op       = lsk_pkg::op_t'(s_tuser);
  assign value    = s_tdata[W-1:0];
  assign position = s_tdata[W +: lsk_pkg::POS_W];
  assign s_tready = !out_valid || m_tready;
  assign take     = s_tvalid && s_tready;

  assign fill_ext = lsk_pkg::CMP_W'(fill);
  assign pos_ext  = lsk_pkg::CMP_W'(position);
  assign is_empty = (fill == '0);
  assign is_full  = (fill_ext >= lsk_pkg::CMP_W'(N));
  assign in_range = (pos_ext != '0) && (pos_ext <= fill_ext);

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < N; i++) begin
      hit[i] = (pos_ext == lsk_pkg::CMP_W'(i + 1));
      if (hit[i]) begin
        sel_word = sel_word | words[i];
      end
    end
  end

  always_comb begin
    fill_next   = fill;
    status_next = lsk_pkg::ST_OK;
    data_next   = '0;
    unique case (op) inside
      lsk_pkg::OP_PUSH: begin
        if (is_full) begin
          status_next = lsk_pkg::ST_FULL;
        end else begin
          fill_next = fill + 1'b1;
        end
      end
      lsk_pkg::OP_POP: begin
        if (is_empty) begin
          status_next = lsk_pkg::ST_EMPTY;
          data_next   = '1;
        end else begin
          fill_next = fill - 1'b1;
          data_next = words[0];
        end
      end
      lsk_pkg::OP_PEEK, lsk_pkg::OP_CHANGE: begin
        if (is_empty) begin
          status_next = lsk_pkg::ST_EMPTY;
        end else if (!in_range) begin
          status_next = lsk_pkg::ST_RANGE;
        end else if (op == lsk_pkg::OP_PEEK) begin
          data_next = sel_word;
        end
      end
      default: begin
        status_next = lsk_pkg::ST_OK;
      end
    endcase
  end

  assign fill_next_ext = lsk_pkg::CMP_W'(fill_next);

  generate
    for (genvar g = 0; g < N; g++) begin : g_cell
      lsk_pkg::cell_ctrl_t ctrl;
      logic signed [W-1:0] above;
      logic signed [W-1:0] below;

      assign ctrl.push = take && (op == lsk_pkg::OP_PUSH) && !is_full;
      assign ctrl.pop  = take && (op == lsk_pkg::OP_POP) && !is_empty;
      assign ctrl.load = take && (op == lsk_pkg::OP_CHANGE) && !is_empty && in_range && hit[g];

      if (g == 0) begin : g_top
        assign above = value;
      end else begin : g_mid
        assign above = words[g-1];
      end
      if (g == N - 1) begin : g_bot
        assign below = words[g];
      end else begin : g_up
        assign below = words[g+1];
      end

      lsk_cell u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .above (above),
        .below (below),
        .value (value),
        .word  (words[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data   <= data_next;
      out_status <= status_next;
      out_depth  <= fill_next_ext[lsk_pkg::POS_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(lsk_pkg::TDATA_W - W - lsk_pkg::POS_W){1'b0}}, out_depth, out_data};
  assign m_tuser  = out_status;

endmodule

### design/lsk_checker.sv
module lsk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [lsk_pkg::TDATA_W-1:0]   s_tdata,
  input logic [1:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lsk_pkg::TDATA_W-1:0]   m_tdata,
  input logic [1:0]                    m_tuser
);

  localparam int DW = lsk_pkg::WORD_W;
  localparam int PW = lsk_pkg::POS_W;
  localparam int CW = lsk_pkg::CMP_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(lsk_pkg::STACK_DEPTH);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("request beat gave no result next cycle");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lsk_pkg::ST_FULL) |-> m_tdata[DW +: PW] == FULL_CNT[PW-1:0])
    else $error("full status with stack not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lsk_pkg::ST_EMPTY) |-> m_tdata[DW +: PW] == '0)
    else $error("empty status with entries held");

endmodule

bind lifo_stack_with_peek_and_modify lsk_checker u_lsk_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PAD_W       = lsk_pkg::TDATA_W - lsk_pkg::WORD_W - lsk_pkg::POS_W;

  typedef struct packed {
    logic [lsk_pkg::WORD_W-1:0] data;
    lsk_pkg::status_t           status;
    logic [lsk_pkg::POS_W-1:0]  depth;
  } stack_result_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [lsk_pkg::TDATA_W-1:0] s_tdata;  // value[31:0], position[36:32], zero pad
  logic [1:0]                  s_tuser;  // opcode[1:0]
  logic                        m_tvalid;
  logic                        m_tready;
  logic [lsk_pkg::TDATA_W-1:0] m_tdata;  // data[31:0], depth_now[36:32], zero pad
  logic [1:0]                  m_tuser;  // status[1:0]

  logic [lsk_pkg::WORD_W-1:0] stack_mem [lsk_pkg::STACK_DEPTH];
  int                         stack_fill;
  stack_result_t              result_q [$];
  int                         err_cnt;
  int                         cycle_cnt;
  int                         tx_gap_max;
  int                         rx_stall_max;
  int                         rx_hold;

  lifo_stack_with_peek_and_modify u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lifo_stack_with_peek_and_modify: mismatch");
      $finish;
    end
  end

  function automatic stack_result_t stack_apply(lsk_pkg::op_t op,
                                                logic [lsk_pkg::WORD_W-1:0] value,
                                                logic [lsk_pkg::POS_W-1:0] pos);
    stack_result_t r;
    int            slot;
    r.data   = '0;
    r.status = lsk_pkg::ST_OK;
    case (op)
      lsk_pkg::OP_PUSH: begin
        if (stack_fill >= lsk_pkg::STACK_DEPTH) begin
          r.status = lsk_pkg::ST_FULL;
        end else begin
          stack_mem[stack_fill] = value;
          stack_fill++;
        end
      end
      lsk_pkg::OP_POP: begin
        if (stack_fill == 0) begin
          r.status = lsk_pkg::ST_EMPTY;
          r.data   = '1;
        end else begin
          stack_fill--;
          r.data = stack_mem[stack_fill];
        end
      end
      default: begin
        if (stack_fill == 0) begin
          r.status = lsk_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > stack_fill) begin
          r.status = lsk_pkg::ST_RANGE;
        end else begin
          slot = stack_fill - pos;
          if (op == lsk_pkg::OP_PEEK) r.data = stack_mem[slot];
          else stack_mem[slot] = value;
        end
      end
    endcase
    r.depth = lsk_pkg::POS_W'(stack_fill);
    return r;
  endfunction

  task automatic send_beat(lsk_pkg::op_t op, logic [lsk_pkg::WORD_W-1:0] value,
                           logic [lsk_pkg::POS_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, pos, value};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    result_q.push_back(stack_apply(op, value, pos));
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [lsk_pkg::WORD_W-1:0] exp_v,
                             logic [lsk_pkg::WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  // receiver: random stall after each accepted beat
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  = rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    stack_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      rx_hold = $urandom_range(0, rx_stall_max);
      if (result_q.size() == 0) begin
        err_cnt++;
        $error("unexpected result beat: data %0h status %0d",
               m_tdata[lsk_pkg::WORD_W-1:0], m_tuser);
      end else begin
        exp_r = result_q.pop_front();
        check_field("data", exp_r.data, m_tdata[lsk_pkg::WORD_W-1:0]);
        check_field("status", lsk_pkg::WORD_W'(exp_r.status), lsk_pkg::WORD_W'(m_tuser));
        check_field("depth_now", lsk_pkg::WORD_W'(exp_r.depth),
                    lsk_pkg::WORD_W'(m_tdata[lsk_pkg::WORD_W +: lsk_pkg::POS_W]));
      end
    end
  end

  task automatic test_empty_stack();
    send_beat(lsk_pkg::OP_POP, 32'h1234_5678, 5'd1);
    send_beat(lsk_pkg::OP_PEEK, '0, 5'd1);
    send_beat(lsk_pkg::OP_CHANGE, 32'hdead_beef, 5'd0);
  endtask

  task automatic test_fill_to_full();
    logic [lsk_pkg::WORD_W-1:0] fill_words [4];
    fill_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    for (int i = 0; i < lsk_pkg::STACK_DEPTH; i++) begin
      if (i < 4) send_beat(lsk_pkg::OP_PUSH, fill_words[i], 5'd0);
      else if (i[0]) send_beat(lsk_pkg::OP_PUSH, 32'haaaa_aaaa ^ i, 5'(i));
      else send_beat(lsk_pkg::OP_PUSH, 32'h5555_5555 ^ i, 5'(i));
    end
    send_beat(lsk_pkg::OP_PUSH, 32'h0bad_cafe, 5'd31);
  endtask

  task automatic test_peek_and_change();
    send_beat(lsk_pkg::OP_PEEK, '0, 5'd0);
    send_beat(lsk_pkg::OP_PEEK, '0, 5'(lsk_pkg::STACK_DEPTH));
    send_beat(lsk_pkg::OP_PEEK, '0, 5'(lsk_pkg::STACK_DEPTH + 1));
    send_beat(lsk_pkg::OP_CHANGE, 32'h1357_9bdf, 5'd1);
    send_beat(lsk_pkg::OP_PEEK, '0, 5'd1);
  endtask

  task automatic test_pause_then_pop();
    wait_all_results();
    send_beat(lsk_pkg::OP_POP, '0, 5'd0);
    send_beat(lsk_pkg::OP_POP, '0, 5'd0);
  endtask

  task automatic test_random_traffic(int n_beats);
    int                         r;
    int                         mode;
    lsk_pkg::op_t               op;
    logic [lsk_pkg::WORD_W-1:0] value;
    logic [lsk_pkg::POS_W-1:0]  pos;
    int                         push_lim;
    int                         pop_lim;
    int                         peek_lim;
    for (int i = 0; i < n_beats; i++) begin
      if (i % 32 == 0) begin
        mode         = $urandom_range(0, 3);
        tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
        rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
        if ($urandom_range(0, 7) == 0) wait_all_results();
        case (mode)
          0:       begin push_lim = 60; pop_lim = 75; peek_lim = 90; end
          1:       begin push_lim = 15; pop_lim = 65; peek_lim = 85; end
          2:       begin push_lim = 30; pop_lim = 60; peek_lim = 80; end
          default: begin push_lim = 20; pop_lim = 40; peek_lim = 75; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < push_lim) op = lsk_pkg::OP_PUSH;
      else if (r < pop_lim) op = lsk_pkg::OP_POP;
      else if (r < peek_lim) op = lsk_pkg::OP_PEEK;
      else op = lsk_pkg::OP_CHANGE;
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
        default: value = $urandom;
      endcase
      r = $urandom_range(0, 9);
      if (stack_fill > 0 && r < 8) pos = 5'($urandom_range(1, stack_fill));
      else if (r == 8) pos = 5'(stack_fill + 1);
      else pos = 5'($urandom_range(0, 31));
      send_beat(op, value, pos);
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    stack_fill   = 0;
    rx_hold      = 0;
    tx_gap_max   = 0;
    rx_stall_max = 6;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_stack();
    test_fill_to_full();
    tx_gap_max = 6;
    test_peek_and_change();
    test_pause_then_pop();
    test_random_traffic(1820);

    wait_all_results();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("lifo_stack_with_peek_and_modify: match");
    end else begin
      $display("lifo_stack_with_peek_and_modify: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/lsk_pkg.sv
design/lsk_cell.sv
design/lifo_stack_with_peek_and_modify.sv
design/lsk_checker.sv
dv/tb_top.sv
